// ===== src/sgls_pkg.sv =====
// ----------------------------------------------------------------------------
// sgls_pkg
// Shared types, widths and helpers for the stage gap latency statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sgls_pkg;

  localparam int NUM_STAGES_DEF = 7;
  localparam int N_STAGE_FIELDS = 7;
  localparam int STAMP_W        = 64;
  localparam int GAP_US_W       = 55;
  localparam int COUNT_W        = 32;
  localparam int SUM_W          = 64;
  localparam int AVG_W          = 62;
  localparam int FRAC_BITS      = 8;
  localparam int GAP_INDEX_W    = 3;
  localparam int NS_PER_US      = 1000;

  localparam int DIVIDEND_W = SUM_W + FRAC_BITS;
  localparam int DIVISOR_W  = COUNT_W;
  localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

  localparam int CHUNK_W     = 16;
  localparam int SCALE_STEPS = STAMP_W / CHUNK_W;
  localparam int NS_REM_W    = 10;
  localparam int SCALE_V_W   = NS_REM_W + CHUNK_W;
  localparam int SCALE_SHIFT = 36;
  localparam int SCALE_MUL_W = 27;
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL =
    SCALE_MUL_W'(((64'd1 << SCALE_SHIFT) + 64'(NS_PER_US) - 64'd1) / 64'(NS_PER_US));

  localparam logic CMD_RECORD  = 1'b0;
  localparam logic CMD_PUBLISH = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [STAMP_W-1:0] stage_time_0;
    logic [STAMP_W-1:0] stage_time_1;
    logic [STAMP_W-1:0] stage_time_2;
    logic [STAMP_W-1:0] stage_time_3;
    logic [STAMP_W-1:0] stage_time_4;
    logic [STAMP_W-1:0] stage_time_5;
    logic [STAMP_W-1:0] stage_time_6;
  } in_item_t;

  typedef struct packed {
    logic [GAP_INDEX_W-1:0] gap_index;
    logic [AVG_W-1:0]       average_q8;
    logic [GAP_US_W-1:0]    maximum_us;
    logic                   last_gap;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic                  scale;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [STAMP_W-1:0] stage_field(input in_item_t d, input int s);
    logic [STAMP_W-1:0] v;
    case (s)
      0:       v = d.stage_time_0;
      1:       v = d.stage_time_1;
      2:       v = d.stage_time_2;
      3:       v = d.stage_time_3;
      4:       v = d.stage_time_4;
      5:       v = d.stage_time_5;
      6:       v = d.stage_time_6;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/sgls_divider.sv =====
// ----------------------------------------------------------------------------
// sgls_divider
// Shared divider: restoring division, one quotient bit per cycle, for the
// averages, and ns-to-us scaling by reciprocal multiplication, one 16-bit
// chunk per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sgls_divider
  import sgls_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                  busy_r,  busy_nxt;
  logic                  done_r,  done_nxt;
  logic                  mode_r,  mode_nxt;
  logic [STEP_W-1:0]     step_r,  step_nxt;
  logic [DIVIDEND_W-1:0] quo_r,   quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r,   rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r,   dvs_nxt;

  logic [DIVISOR_W:0]    partial;
  logic [DIVISOR_W+1:0]  trial;
  logic                  fits;

  logic [SCALE_V_W-1:0]             scale_v;
  logic [SCALE_V_W+SCALE_MUL_W-1:0] scale_prod;
  logic [CHUNK_W-1:0]               scale_q;
  logic [NS_REM_W-1:0]              scale_rem;

  assign partial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial   = {1'b0, partial} - {2'b00, dvs_r};
  assign fits    = ~trial[DIVISOR_W+1];

  assign scale_v    = {rem_r[NS_REM_W-1:0], quo_r[DIVIDEND_W-1 -: CHUNK_W]};
  assign scale_prod = {{SCALE_MUL_W{1'b0}}, scale_v} * {{SCALE_V_W{1'b0}}, SCALE_MUL};
  assign scale_q    = scale_prod[SCALE_SHIFT +: CHUNK_W];
  assign scale_rem  = scale_v[NS_REM_W-1:0] - NS_REM_W'(scale_q * NS_REM_W'(NS_PER_US));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      mode_nxt = req.scale;
      step_nxt = '0;
      quo_nxt  = req.scale ? (req.dividend << (DIVIDEND_W - STAMP_W)) : req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r && mode_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-CHUNK_W-1:0], scale_q};
      rem_nxt = {{(DIVISOR_W - NS_REM_W){1'b0}}, scale_rem};
      if (step_r == STEP_W'(SCALE_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? trial[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
      if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    mode_r <= mode_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ===== src/stage_gap_latency_stats_unit.sv =====
// ----------------------------------------------------------------------------
// stage_gap_latency_stats_unit
// Per-gap count, sum and maximum of inter-stage latencies, published as
// fixed point averages and maxima.
// ----------------------------------------------------------------------------
// Record beat: an absent gap takes only the setup state; a present gap takes
//   setup, 4 scaling steps, result and update.
// Publish beat: a gap with samples takes setup, 72 divider steps, result and
//   output, an empty gap setup and output; output stall holds it. One output beat per gap.
// Reset (synchronous, rst_n low) clears all accumulators and control state.
// ----------------------------------------------------------------------------
`default_nettype none

module stage_gap_latency_stats_unit
  import sgls_pkg::*;
#(
  parameter int NUM_STAGES = NUM_STAGES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int NUM_GAPS = NUM_STAGES - 1;
  localparam int GAP_W    = (NUM_GAPS > 1) ? $clog2(NUM_GAPS) : 1;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_REC_SETUP = 3'd1;
  localparam logic [2:0] ST_REC_DIV   = 3'd2;
  localparam logic [2:0] ST_REC_UPD   = 3'd3;
  localparam logic [2:0] ST_PUB_SETUP = 3'd4;
  localparam logic [2:0] ST_PUB_DIV   = 3'd5;
  localparam logic [2:0] ST_PUB_OUT   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [GAP_W-1:0]    gap_r,   gap_nxt;
  logic [AVG_W-1:0]    avg_r,   avg_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r,  out_data_nxt;

  logic [STAMP_W-1:0]  stamp_r [NUM_STAGES];
  logic [STAMP_W-1:0]  in_stamp [NUM_STAGES];
  logic [COUNT_W-1:0]  count_r [NUM_GAPS];
  logic [SUM_W-1:0]    sum_r   [NUM_GAPS];
  logic [GAP_US_W-1:0] max_r   [NUM_GAPS];

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                in_take;
  logic                present;
  logic [STAMP_W-1:0]  diff;
  logic                last;
  logic                shift_en;
  logic                upd_en;
  logic                clr_en;
  logic [GAP_US_W-1:0] gap_us;
  logic [SUM_W:0]      sum_ext;
  logic                out_free;

  sgls_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_in_stamp
    assign in_stamp[s] = stage_field(in_data, s);
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign present  = (stamp_r[0] != '0) && (stamp_r[1] != '0);
  assign diff     = stamp_r[1] - stamp_r[0];
  assign last     = (gap_r == GAP_W'(NUM_GAPS - 1));
  assign gap_us   = div_rsp.quotient[GAP_US_W-1:0];
  assign sum_ext  = {1'b0, sum_r[gap_r]} + {{(SUM_W + 1 - GAP_US_W){1'b0}}, gap_us};
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.scale    = 1'b1;
    div_req.dividend = {{FRAC_BITS{1'b0}}, diff};
    div_req.divisor  = DIVISOR_W'(NS_PER_US);
    if (state_r == ST_REC_SETUP) begin
      div_req.start = present;
    end else if (state_r == ST_PUB_SETUP) begin
      div_req.start    = (count_r[gap_r] != '0);
      div_req.scale    = 1'b0;
      div_req.dividend = {sum_r[gap_r], {FRAC_BITS{1'b0}}};
      div_req.divisor  = count_r[gap_r];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    gap_nxt       = gap_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    shift_en      = 1'b0;
    upd_en        = 1'b0;
    clr_en        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        gap_nxt = '0;
        if (in_take) begin
          state_nxt = (in_data.cmd == CMD_PUBLISH) ? ST_PUB_SETUP : ST_REC_SETUP;
        end
      end
      ST_REC_SETUP: begin
        if (present) begin
          state_nxt = ST_REC_DIV;
        end else begin
          shift_en  = 1'b1;
          state_nxt = last ? ST_IDLE : ST_REC_SETUP;
          gap_nxt   = last ? gap_r : gap_r + GAP_W'(1);
        end
      end
      ST_REC_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_REC_UPD;
        end
      end
      ST_REC_UPD: begin
        upd_en    = 1'b1;
        shift_en  = 1'b1;
        state_nxt = last ? ST_IDLE : ST_REC_SETUP;
        gap_nxt   = last ? gap_r : gap_r + GAP_W'(1);
      end
      ST_PUB_SETUP: begin
        if (count_r[gap_r] == '0) begin
          avg_nxt   = '0;
          state_nxt = ST_PUB_OUT;
        end else begin
          state_nxt = ST_PUB_DIV;
        end
      end
      ST_PUB_DIV: begin
        if (div_rsp.done) begin
          avg_nxt = (div_rsp.quotient[DIVIDEND_W-1:AVG_W] != '0) ? '1
                                                                 : div_rsp.quotient[AVG_W-1:0];
          state_nxt = ST_PUB_OUT;
        end
      end
      ST_PUB_OUT: begin
        if (out_free) begin
          clr_en                  = 1'b1;
          out_valid_nxt           = 1'b1;
          out_data_nxt.gap_index  = GAP_INDEX_W'(gap_r);
          out_data_nxt.average_q8 = avg_r;
          out_data_nxt.maximum_us = max_r[gap_r];
          out_data_nxt.last_gap   = last;
          state_nxt               = last ? ST_IDLE : ST_PUB_SETUP;
          gap_nxt                 = last ? gap_r : gap_r + GAP_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gap_r       <= '0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < NUM_GAPS; g++) begin
        count_r[g] <= '0;
        sum_r[g]   <= '0;
        max_r[g]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      gap_r       <= gap_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd_en) begin
        if (count_r[gap_r] != '1) begin
          count_r[gap_r] <= count_r[gap_r] + COUNT_W'(1);
        end
        sum_r[gap_r] <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        if (gap_us > max_r[gap_r]) begin
          max_r[gap_r] <= gap_us;
        end
      end
      if (clr_en) begin
        count_r[gap_r] <= '0;
        sum_r[gap_r]   <= '0;
        max_r[gap_r]   <= '0;
      end
    end
    avg_r      <= avg_nxt;
    out_data_r <= out_data_nxt;
    if (in_take) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        stamp_r[s] <= in_stamp[s];
      end
    end else if (shift_en) begin
      for (int s = 0; s < NUM_STAGES - 1; s++) begin
        stamp_r[s] <= stamp_r[s+1];
      end
      stamp_r[NUM_STAGES-1] <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_upd_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REC_UPD) |-> $past(div_rsp.done))
    else $error("gap update without a finished division");

  a_gap_range: assert property (@(posedge clk) disable iff (!rst_n)
    gap_r <= GAP_W'(NUM_GAPS - 1))
    else $error("gap counter out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled output beat overwritten");

endmodule

`default_nettype wire

// ===== sim/gap_stats_checker.sv =====
// ----------------------------------------------------------------------------
// gap_stats_checker
// Watches both channels of the stage gap latency statistics unit. Keeps its
// own per-gap count, sum and maximum, turns each publish beat into one expected
// result beat per gap and compares every result beat, field by field, with
// the oldest expectation.
// ----------------------------------------------------------------------------
module gap_stats_checker
  import sgls_pkg::*;
#(
  parameter int NUM_STAGES = NUM_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          N_GAPS   = NUM_STAGES - 1;
  localparam int          MAX_LOGS = 100;
  localparam logic [63:0] US_DIV   = 64'(NS_PER_US);
  localparam logic [63:0] AVG_CEIL = (64'd1 << AVG_W) - 64'd1;

  logic [COUNT_W-1:0]  gap_tally [N_GAPS];
  logic [SUM_W-1:0]    gap_total [N_GAPS];
  logic [GAP_US_W-1:0] gap_peak  [N_GAPS];
  out_item_t           expected_stats [$];
  out_item_t           want;
  int                  mismatches = 0;
  int                  pending = 0;

  assign fail_count      = mismatches;
  assign results_pending = pending;

  function automatic logic [STAMP_W-1:0] stamp_of(input in_item_t d, input int s);
    logic [$bits(in_item_t)-1:0] flat;
    flat = d;
    if (s >= N_STAGE_FIELDS) begin
      return '0;
    end
    return flat[STAMP_W*(N_STAGE_FIELDS-1-s) +: STAMP_W];
  endfunction

  function automatic logic [AVG_W-1:0] mean_q8(input logic [SUM_W-1:0] total,
                                              input logic [COUNT_W-1:0] n);
    logic [63:0] whole;
    logic [63:0] rest;
    if (n == '0) begin
      return '0;
    end
    whole = total / n;
    rest  = total % n;
    if (whole > (AVG_CEIL >> FRAC_BITS)) begin
      return AVG_CEIL[AVG_W-1:0];
    end
    return AVG_W'((whole << FRAC_BITS) + ((rest << FRAC_BITS) / n));
  endfunction

  task automatic clear_stats();
    for (int i = 0; i < N_GAPS; i++) begin
      gap_tally[i] = '0;
      gap_total[i] = '0;
      gap_peak[i]  = '0;
    end
  endtask

  task automatic accumulate_gaps(input in_item_t d);
    logic [63:0] early;
    logic [63:0] late;
    logic [63:0] span;
    for (int i = 0; i < N_GAPS; i++) begin
      early = stamp_of(d, i);
      late  = stamp_of(d, i + 1);
      if (early == '0 || late == '0) begin
        continue;
      end
      span = (late - early) / US_DIV;
      if (gap_tally[i] != '1) begin
        gap_tally[i]++;
      end
      if (gap_total[i] > ~span) begin
        gap_total[i] = '1;
      end else begin
        gap_total[i] = gap_total[i] + span;
      end
      if (span > 64'(gap_peak[i])) begin
        gap_peak[i] = span[GAP_US_W-1:0];
      end
    end
  endtask

  task automatic publish_gaps();
    out_item_t r;
    for (int i = 0; i < N_GAPS; i++) begin
      r.gap_index  = GAP_INDEX_W'(i);
      r.average_q8 = mean_q8(gap_total[i], gap_tally[i]);
      r.maximum_us = gap_peak[i];
      r.last_gap   = (i == N_GAPS - 1);
      expected_stats = {expected_stats, r};
    end
    clear_stats();
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_LOGS) begin
      $display("%0t ns  mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stats();
      expected_stats.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_stats.size() == 0) begin
          flag_mismatch($sformatf("result beat with none expected, gap_index %0d",
                                  out_data.gap_index));
        end else begin
          want = expected_stats.pop_front();
          if (out_data.gap_index !== want.gap_index) begin
            flag_mismatch($sformatf("gap_index got %0d want %0d",
                                    out_data.gap_index, want.gap_index));
          end
          if (out_data.average_q8 !== want.average_q8) begin
            flag_mismatch($sformatf("gap %0d average_q8 got %h want %h", want.gap_index,
                                    out_data.average_q8, want.average_q8));
          end
          if (out_data.maximum_us !== want.maximum_us) begin
            flag_mismatch($sformatf("gap %0d maximum_us got %h want %h", want.gap_index,
                                    out_data.maximum_us, want.maximum_us));
          end
          if (out_data.last_gap !== want.last_gap) begin
            flag_mismatch($sformatf("gap %0d last_gap got %b want %b", want.gap_index,
                                    out_data.last_gap, want.last_gap));
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        if (in_data.cmd == CMD_PUBLISH) begin
          publish_gaps();
        end else begin
          accumulate_gaps(in_data);
        end
      end
    end
    pending = expected_stats.size();
  end

endmodule

// ===== sim/stage_gap_latency_stats_unit_test.sv =====
// ----------------------------------------------------------------------------
// stage_gap_latency_stats_unit_test
// Drives record and publish beats into the stage gap latency statistics unit
// under random idling on both channels: a directed opening, a run that drives
// one gap's average past its ceiling, a receiver hold-off that backs the unit
// up, and random timestamp sets. The checker predicts and compares the results.
// ----------------------------------------------------------------------------
module stage_gap_latency_stats_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sgls_pkg::*;

  localparam int          HOLD_CYCLES  = 2000;
  localparam int          DRAIN_CYCLES = 600;
  localparam int          RANDOM_BEATS = 70;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_requests;
  int        fail_count;
  int        results_pending;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  stage_gap_latency_stats_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  gap_stats_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  function automatic in_item_t stamp_beat(input logic [63:0] t0, t1, t2, t3, t4, t5, t6);
    in_item_t b;
    b.cmd          = CMD_RECORD;
    b.stage_time_0 = t0;
    b.stage_time_1 = t1;
    b.stage_time_2 = t2;
    b.stage_time_3 = t3;
    b.stage_time_4 = t4;
    b.stage_time_5 = t5;
    b.stage_time_6 = t6;
    return b;
  endfunction

  function automatic in_item_t publish_beat();
    in_item_t b;
    b = stamp_beat({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom});
    b.cmd = CMD_PUBLISH;
    return b;
  endfunction

  function automatic in_item_t random_record();
    logic [63:0] t [7];
    logic [63:0] base;
    int          mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      base = ALL_ONES - $urandom_range(0, 20_000_000);
    end else begin
      base = {$urandom, $urandom};
    end
    for (int s = 0; s < 7; s++) begin
      case (mode)
        7, 8: begin
          t[s] = {$urandom, $urandom};
        end
        9: begin
          t[s] = 64'($urandom_range(0, 3000));
        end
        default: begin
          t[s] = base;
          if (mode == 6 && $urandom_range(0, 5) == 0) begin
            base = base - $urandom_range(1, 5_000_000);
          end else begin
            base = base + $urandom_range(0, 5_000_000);
          end
        end
      endcase
      if ($urandom_range(0, 99) < 15) begin
        t[s] = '0;
      end
    end
    return stamp_beat(t[0], t[1], t[2], t[3], t[4], t[5], t[6]);
  endfunction

  task automatic send_beat(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 12) begin
        send_beat(publish_beat());
      end else begin
        send_beat(random_record());
      end
    end
  endtask

  initial begin : limit
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : receiver
    int served;
    served    = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 7;
    recv_idle_pct = 65;
    send_beat(publish_beat());
    send_beat(stamp_beat(1000, 2000, 3999, 5000, 5999, 7000, 8000));
    send_beat(stamp_beat(1, ALL_ONES, ALL_ONES, 2, 0, 500, 1));
    send_beat(stamp_beat(0, 0, 0, 0, 0, 0, 0));
    send_beat(stamp_beat(0, 3000, 9000, 9500, 0, 12000, 40000));
    send_beat(stamp_beat(10_000, 11_000, 11_500, 11_600, 12_000, 12_001, 12_999));
    send_beat(stamp_beat(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                         ALL_ONES));
    send_beat(stamp_beat(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                         64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                         64'h0000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000,
                         64'h0000_0000_FFFF_FFFF));
    send_beat(publish_beat());
    send_beat(stamp_beat(1000, 2000, 3000, 4000, 5000, 6000, 7000));
    send_beat(stamp_beat(2000, 4000, 6000, 8000, 10000, 12000, 14000));
    send_beat(stamp_beat(2000, 4000, 6000, 8000, 10000, 12000, 14000));
    send_beat(publish_beat());
    send_beat(stamp_beat(2, 1, 2, 1, 2, 1, 2));
    send_beat(publish_beat());
    send_beat(publish_beat());
    run_random(RANDOM_BEATS);
    wait_drained();

    send_idle_pct = 65;
    recv_idle_pct = 7;
    run_random(RANDOM_BEATS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    send_beat(stamp_beat(100, 2100, 5100, 9100, 9200, 9300, 19300));
    send_beat(publish_beat());
    send_beat(random_record());
    send_beat(random_record());
    send_beat(publish_beat());
    send_beat(random_record());
    wait_drained();

    // push one gap's average past its ceiling, then pull it back below
    repeat (10) send_beat(stamp_beat(0, 0, 2, 1, 0, 0, 0));
    repeat (4) send_beat(stamp_beat(0, 0, 5, 5, 0, 0, 0));
    send_beat(publish_beat());
    run_random(RANDOM_BEATS);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sgls_pkg.sv
src/sgls_divider.sv
src/stage_gap_latency_stats_unit.sv
sim/gap_stats_checker.sv
sim/stage_gap_latency_stats_unit_test.sv
